@@ rtl/bli_pkg.sv @@
// ----------------------------------------------------------------------------
// bli_pkg
// Shared types and constants for the breakpoint linear interpolator.
// ----------------------------------------------------------------------------
package bli_pkg;

    localparam int FIELD_W   = 24;
    localparam int COUNT_W   = 5;
    localparam int INDEX_W   = 4;
    localparam int DIFF_W    = FIELD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    // |product| < 2^48 and quotient < 2^24 once the bracketing pair is found
    localparam int DIVIDEND_W = 2 * FIELD_W;
    localparam int DIV_STEPS  = FIELD_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int SUM_W      = FIELD_W + 2;

    localparam logic signed [SUM_W-1:0] VALUE_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] VALUE_MIN = -SUM_W'(8388608);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] bp_time;
        logic signed [FIELD_W-1:0] bp_value;
    } bli_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HI,
        ST_LO,
        ST_MID,
        ST_DIFF,
        ST_MUL,
        ST_DSTART,
        ST_DIV
    } bli_state_t;

endpackage

@@ rtl/bli_table.sv @@
// ----------------------------------------------------------------------------
// bli_table
// Breakpoint memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bli_table
    import bli_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  bli_entry_t    wr_data,
    input  logic [AW-1:0] rd_addr,
    output bli_entry_t    rd_data
);

    bli_entry_t mem [DEPTH];
    bli_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bli_div.sv @@
// ----------------------------------------------------------------------------
// bli_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module bli_div
    import bli_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [FIELD_W-1:0]    divisor,
    output logic                  busy,
    output logic                  done,
    output logic [FIELD_W-1:0]    quotient
);

    logic [FIELD_W-1:0] rem_reg,  rem_next;
    logic [FIELD_W-1:0] acc_reg,  acc_next;
    logic [FIELD_W-1:0] dvs_reg,  dvs_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               run_reg,  run_next;
    logic               done_reg, done_next;
    logic [FIELD_W:0]   partial;
    logic [FIELD_W+1:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        partial   = {rem_reg, acc_reg[FIELD_W-1]};
        trial     = {1'b0, partial} - {2'b00, dvs_reg};
        if (start)
        begin
            // upper half is already below the divisor
            rem_next  = dividend[DIVIDEND_W-1:FIELD_W];
            acc_next  = dividend[FIELD_W-1:0];
            dvs_next  = divisor;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[FIELD_W+1])
            begin
                rem_next = trial[FIELD_W-1:0];
                acc_next = {acc_reg[FIELD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[FIELD_W-1:0];
                acc_next = {acc_reg[FIELD_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = run_reg;
    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

@@ rtl/breakpoint_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// breakpoint_linear_interpolator
// Piecewise linear curve lookup over a table of time/value breakpoints.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     start & !busy        op, entry_index, entry_time, entry_value,
//                                 query_time
//  result    done (one cycle)     curve_value
//  config    cfg_valid&cfg_ready  cfg_data (entry_count)
//
// a write item completes in the cycle it is accepted; busy stays low
// a query steps through ST_HI, ST_LO, the ST_MID search, ST_DIFF, ST_MUL,
// ST_DSTART and the bit-serial divide in ST_DIV; clamped answers end early
// done pulses in the first cycle with busy low; the receiver cannot stall
// reset sets entry_count to 1; table contents are undefined until written
// ----------------------------------------------------------------------------
module breakpoint_linear_interpolator
    import bli_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      op,
    input  logic [INDEX_W-1:0]        entry_index,
    input  logic signed [FIELD_W-1:0] entry_time,
    input  logic signed [FIELD_W-1:0] entry_value,
    input  logic signed [FIELD_W-1:0] query_time,
    output logic                      done,
    output logic signed [FIELD_W-1:0] curve_value,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [COUNT_W-1:0]        cfg_data
);

    localparam int AW = $clog2(MAX_ENTRIES);

    bli_state_t state_reg, state_next;

    logic [COUNT_W-1:0]        entry_count_reg;
    logic [AW-1:0]             last_idx;
    logic [AW-1:0]             lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [AW-1:0]             lo_cur, hi_cur, mid_calc;
    logic [AW:0]               idx_sum;
    logic                      more;
    logic signed [FIELD_W-1:0] t_reg, t_next;
    logic signed [FIELD_W-1:0] t_lo_reg, t_lo_next, v_lo_reg, v_lo_next;
    logic signed [FIELD_W-1:0] t_hi_reg, t_hi_next, v_hi_reg, v_hi_next;
    logic signed [DIFF_W-1:0]  dv_reg, dv_next, dt_reg, dt_next, dur_reg, dur_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [PROD_W-1:0]         prod_mag;
    logic                      neg_reg, neg_next;
    logic signed [FIELD_W-1:0] result_reg, result_next;
    logic                      done_reg, done_next;
    logic signed [SUM_W-1:0]   quot_signed, sum;

    logic                      wr_en;
    logic [AW-1:0]             rd_addr;
    bli_entry_t                wr_data, rd_entry;

    logic                      div_start, div_busy, div_done;
    logic [FIELD_W-1:0]        quotient;

    bli_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(entry_index)),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    bli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag[DIVIDEND_W-1:0]),
        .divisor  (dur_reg[FIELD_W-1:0]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign curve_value = result_reg;

    assign wr_en   = start && !busy && (op == OP_WRITE)
                     && (32'(entry_index) < MAX_ENTRIES);
    assign wr_data = '{bp_time: entry_time, bp_value: entry_value};

    // zero count behaves as one entry, large counts saturate
    always_comb
    begin
        if (entry_count_reg == '0)
            last_idx = '0;
        else if (32'(entry_count_reg) > MAX_ENTRIES)
            last_idx = AW'(MAX_ENTRIES - 1);
        else
            last_idx = AW'(32'(entry_count_reg) - 32'd1);
    end

    // search window after this cycle's compare
    always_comb
    begin
        lo_cur = lo_reg;
        hi_cur = hi_reg;
        if (state_reg == ST_MID)
        begin
            if (t_reg >= rd_entry.bp_time)
                lo_cur = mid_reg;
            else
                hi_cur = mid_reg;
        end
        idx_sum  = {1'b0, lo_cur} + {1'b0, hi_cur};
        mid_calc = idx_sum[AW:1];
        more     = (({1'b0, lo_cur} + (AW+1)'(1)) < {1'b0, hi_cur});
    end

    assign prod_mag    = prod_reg[PROD_W-1] ? (~prod_reg + PROD_W'(1)) : prod_reg;
    assign quot_signed = neg_reg ? -{2'b00, quotient} : {2'b00, quotient};
    assign sum         = {{2{v_lo_reg[FIELD_W-1]}}, v_lo_reg} + quot_signed;

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        t_next      = t_reg;
        t_lo_next   = t_lo_reg;
        v_lo_next   = v_lo_reg;
        t_hi_next   = t_hi_reg;
        v_hi_next   = v_hi_reg;
        dv_next     = dv_reg;
        dt_next     = dt_reg;
        dur_next    = dur_reg;
        prod_next   = prod_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        rd_addr     = last_idx;
        div_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (op == OP_QUERY))
                begin
                    t_next     = query_time;
                    lo_next    = '0;
                    hi_next    = last_idx;
                    state_next = ST_HI;
                end
            end
            ST_HI:
            begin
                if (t_reg >= rd_entry.bp_time)
                begin
                    result_next = rd_entry.bp_value;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    t_hi_next  = rd_entry.bp_time;
                    v_hi_next  = rd_entry.bp_value;
                    rd_addr    = '0;
                    state_next = ST_LO;
                end
            end
            ST_LO:
            begin
                if (t_reg <= rd_entry.bp_time)
                begin
                    result_next = rd_entry.bp_value;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    t_lo_next = rd_entry.bp_time;
                    v_lo_next = rd_entry.bp_value;
                    rd_addr   = mid_calc;
                    mid_next  = mid_calc;
                    state_next = more ? ST_MID : ST_DIFF;
                end
            end
            ST_MID:
            begin
                if (t_reg >= rd_entry.bp_time)
                begin
                    t_lo_next = rd_entry.bp_time;
                    v_lo_next = rd_entry.bp_value;
                end
                else
                begin
                    t_hi_next = rd_entry.bp_time;
                    v_hi_next = rd_entry.bp_value;
                end
                lo_next    = lo_cur;
                hi_next    = hi_cur;
                rd_addr    = mid_calc;
                mid_next   = mid_calc;
                state_next = more ? ST_MID : ST_DIFF;
            end
            ST_DIFF:
            begin
                dv_next    = DIFF_W'(v_hi_reg) - DIFF_W'(v_lo_reg);
                dt_next    = DIFF_W'(t_reg) - DIFF_W'(t_lo_reg);
                dur_next   = DIFF_W'(t_hi_reg) - DIFF_W'(t_lo_reg);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (dur_reg <= 0)
                begin
                    // unsorted pair
                    result_next = v_lo_reg;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    prod_next  = dv_reg * dt_reg;
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART:
            begin
                neg_next   = prod_reg[PROD_W-1];
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (sum > VALUE_MAX)
                        result_next = FIELD_W'(VALUE_MAX);
                    else if (sum < VALUE_MIN)
                        result_next = FIELD_W'(VALUE_MIN);
                    else
                        result_next = sum[FIELD_W-1:0];
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            done_reg        <= 1'b0;
            entry_count_reg <= COUNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                entry_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        t_reg      <= t_next;
        t_lo_reg   <= t_lo_next;
        v_lo_reg   <= v_lo_next;
        t_hi_reg   <= t_hi_next;
        v_hi_reg   <= v_hi_next;
        dv_reg     <= dv_next;
        dt_reg     <= dt_next;
        dur_reg    <= dur_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a query is still running");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_QUERY)) |=> busy)
        else $error("query transfer did not start the sequencer");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ST_DIV))
        else $error("divider running outside the divide step");

    a_mid_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MID) |-> ((lo_reg < mid_reg) && (mid_reg < hi_reg)))
        else $error("search midpoint outside its window");

endmodule
